FILE: rtl/qpm_pkg.sv
// Shared types, constants and saturating arithmetic helpers for the quad point mapper.
`default_nettype none

package qpm_pkg;

   localparam int COORD_W       = 32;
   localparam int PROD_W        = 64;
   localparam int SUM_W         = 66;
   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_CSR       = 8;
   localparam int CSR_IDX_W     = 4;
   localparam int CSR_SEL_W     = 3;
   localparam int FIFO_DEPTH_DEF = 4;
   localparam int DIV_STEPS     = 31;
   localparam int REM_W         = 95;

   localparam int CSR_A_X = 0;
   localparam int CSR_A_Y = 1;
   localparam int CSR_B_X = 2;
   localparam int CSR_B_Y = 3;
   localparam int CSR_C_X = 4;
   localparam int CSR_C_Y = 5;
   localparam int CSR_D_X = 6;
   localparam int CSR_D_Y = 7;

   localparam logic [COORD_W-1:0] CSR_RESET [NUM_CSR] = '{
      32'h0000_0000, 32'h0000_0000,
      32'h0001_0000, 32'h0000_0000,
      32'h0001_0000, 32'h0001_0000,
      32'h0000_0000, 32'h0001_0000
   };

   localparam logic signed [COORD_W-1:0] T_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] T_MIN = 32'sh8000_0000;
   localparam logic signed [SUM_W-1:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [SUM_W-1:0] SAT_MIN = -66'sd2147483648;

   typedef struct packed {
      logic signed [COORD_W-1:0] u;
      logic signed [COORD_W-1:0] v;
   } item_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] d_x;
      logic signed [COORD_W-1:0] d_y;
      logic signed [COORD_W-1:0] ba_x;
      logic signed [COORD_W-1:0] ba_y;
      logic signed [COORD_W-1:0] cd_x;
      logic signed [COORD_W-1:0] cd_y;
      logic signed [COORD_W-1:0] da_x;
      logic signed [COORD_W-1:0] da_y;
      logic signed [COORD_W-1:0] cb_x;
      logic signed [COORD_W-1:0] cb_y;
   } geom_type;

   typedef struct packed {
      logic [REM_W-1:0]     rem;
      logic [PROD_W-1:0]    den;
      logic [DIV_STEPS-1:0] quo;
   } div_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ab_x;
      logic signed [COORD_W-1:0] ab_y;
      logic signed [COORD_W-1:0] d1_x;
      logic signed [COORD_W-1:0] d1_y;
      logic                      neg;
      logic                      ovf;
      logic                      zero;
   } side_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
      logic signed [COORD_W-1:0] r;
      if (x > SAT_MAX) begin
         r = T_MAX;
      end else if (x < SAT_MIN) begin
         r = T_MIN;
      end else begin
         r = x[COORD_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] sub_sat(input logic signed [COORD_W-1:0] a,
                                                         input logic signed [COORD_W-1:0] b);
      logic signed [SUM_W-1:0] s;
      s = SUM_W'(a) - SUM_W'(b);
      return sat32(s);
   endfunction

   function automatic logic signed [PROD_W-1:0] mul32(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
      logic signed [PROD_W-1:0] p;
      p = a * b;
      return p;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/qpm_fifo.sv
// Small item queue between the accepting front and the compute back end.
`default_nettype none

module qpm_fifo #(
   parameter int DEPTH = qpm_pkg::FIFO_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  qpm_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output qpm_pkg::item_type  pop_item,
   output logic               empty
);
   import qpm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/qpm_front.sv
// Front end: corner registers, precomputed corner differences and item acceptance.
`default_nettype none

module qpm_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [qpm_pkg::COORD_W-1:0]   req_point_u,
   input  logic signed [qpm_pkg::COORD_W-1:0]   req_point_v,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [qpm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [qpm_pkg::COORD_W-1:0]          csr_wdata,
   input  logic                                 fifo_full,
   output logic                                 fifo_push,
   output qpm_pkg::item_type                    fifo_item,
   output qpm_pkg::geom_type                    geom
);
   import qpm_pkg::*;

   logic [COORD_W-1:0]        corner_ff [NUM_CSR];
   logic [COORD_W-1:0]        corner_in [NUM_CSR];
   logic signed [COORD_W-1:0] ba_x_ff, ba_y_ff, cd_x_ff, cd_y_ff;
   logic signed [COORD_W-1:0] da_x_ff, da_y_ff, cb_x_ff, cb_y_ff;
   logic signed [COORD_W-1:0] ba_x_in, ba_y_in, cd_x_in, cd_y_in;
   logic signed [COORD_W-1:0] da_x_in, da_y_in, cb_x_in, cb_y_in;
   logic                      csr_hit;

   assign csr_ready = 1'b1;
   assign req_stall = fifo_full;
   assign fifo_push = req_valid && !fifo_full;
   assign fifo_item = '{u: req_point_u, v: req_point_v};
   assign csr_hit   = csr_valid && (csr_index < CSR_IDX_W'(NUM_CSR));

   always_comb begin
      corner_in = corner_ff;
      if (csr_hit) begin
         corner_in[csr_index[CSR_SEL_W-1:0]] = csr_wdata;
      end
   end

   // The differences only change after a register write, so they are kept ready.
   always_comb begin
      ba_x_in = sub_sat(corner_ff[CSR_B_X], corner_ff[CSR_A_X]);
      ba_y_in = sub_sat(corner_ff[CSR_B_Y], corner_ff[CSR_A_Y]);
      cd_x_in = sub_sat(corner_ff[CSR_C_X], corner_ff[CSR_D_X]);
      cd_y_in = sub_sat(corner_ff[CSR_C_Y], corner_ff[CSR_D_Y]);
      da_x_in = sub_sat(corner_ff[CSR_D_X], corner_ff[CSR_A_X]);
      da_y_in = sub_sat(corner_ff[CSR_D_Y], corner_ff[CSR_A_Y]);
      cb_x_in = sub_sat(corner_ff[CSR_C_X], corner_ff[CSR_B_X]);
      cb_y_in = sub_sat(corner_ff[CSR_C_Y], corner_ff[CSR_B_Y]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= CSR_RESET;
      end else begin
         corner_ff <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      ba_x_ff <= ba_x_in;
      ba_y_ff <= ba_y_in;
      cd_x_ff <= cd_x_in;
      cd_y_ff <= cd_y_in;
      da_x_ff <= da_x_in;
      da_y_ff <= da_y_in;
      cb_x_ff <= cb_x_in;
      cb_y_ff <= cb_y_in;
   end

   always_comb begin
      geom.a_x  = corner_ff[CSR_A_X];
      geom.a_y  = corner_ff[CSR_A_Y];
      geom.b_x  = corner_ff[CSR_B_X];
      geom.b_y  = corner_ff[CSR_B_Y];
      geom.d_x  = corner_ff[CSR_D_X];
      geom.d_y  = corner_ff[CSR_D_Y];
      geom.ba_x = ba_x_ff;
      geom.ba_y = ba_y_ff;
      geom.cd_x = cd_x_ff;
      geom.cd_y = cd_y_ff;
      geom.da_x = da_x_ff;
      geom.da_y = da_y_ff;
      geom.cb_x = cb_x_ff;
      geom.cb_y = cb_y_ff;
   end

endmodule

`default_nettype wire

FILE: rtl/qpm_div_step.sv
// One registered restoring-division step that decides a single quotient bit.
`default_nettype none

module qpm_div_step #(
   parameter int SHIFT = 0
) (
   input  logic             clock,
   input  logic             step_en,
   input  qpm_pkg::div_type div_i,
   output qpm_pkg::div_type div_o
);
   import qpm_pkg::*;

   div_type          step_ff, step_in;
   logic [REM_W-1:0] sub_d;
   logic [REM_W:0]   trial;

   always_comb begin
      sub_d   = REM_W'(div_i.den) << SHIFT;
      trial   = {1'b0, div_i.rem} - {1'b0, sub_d};
      step_in = div_i;
      if (!trial[REM_W]) begin
         step_in.rem        = trial[REM_W-1:0];
         step_in.quo[SHIFT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         step_ff <= step_in;
      end
   end

   assign div_o = step_ff;

endmodule

`default_nettype wire

FILE: rtl/qpm_back.sv
// Back end: interpolation, line intersection, pipelined division and output register.
`default_nettype none

module qpm_back #(
   parameter int FRAC_BITS = qpm_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  qpm_pkg::geom_type                  geom,
   input  logic                               fifo_empty,
   input  qpm_pkg::item_type                  fifo_item,
   output logic                               fifo_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [qpm_pkg::COORD_W-1:0] rsp_mapped_x,
   output logic signed [qpm_pkg::COORD_W-1:0] rsp_mapped_y,
   output logic                               rsp_lines_parallel
);
   import qpm_pkg::*;

   localparam int NUM_STAGES = 9 + DIV_STEPS;
   localparam int OVF_SHIFT  = DIV_STEPS - FRAC_BITS;

   typedef struct packed {
      logic signed [PROD_W-1:0] p_ab_x;
      logic signed [PROD_W-1:0] p_ab_y;
      logic signed [PROD_W-1:0] p_dc_x;
      logic signed [PROD_W-1:0] p_dc_y;
      logic signed [PROD_W-1:0] p_ad_x;
      logic signed [PROD_W-1:0] p_ad_y;
      logic signed [PROD_W-1:0] p_bc_x;
      logic signed [PROD_W-1:0] p_bc_y;
   } s1_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ab_x;
      logic signed [COORD_W-1:0] ab_y;
      logic signed [COORD_W-1:0] dc_x;
      logic signed [COORD_W-1:0] dc_y;
      logic signed [COORD_W-1:0] ad_x;
      logic signed [COORD_W-1:0] ad_y;
      logic signed [COORD_W-1:0] bc_x;
      logic signed [COORD_W-1:0] bc_y;
   } s2_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ab_x;
      logic signed [COORD_W-1:0] ab_y;
      logic signed [COORD_W-1:0] d1_x;
      logic signed [COORD_W-1:0] d1_y;
      logic signed [COORD_W-1:0] d2_x;
      logic signed [COORD_W-1:0] d2_y;
      logic signed [COORD_W-1:0] w_x;
      logic signed [COORD_W-1:0] w_y;
   } s3_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ab_x;
      logic signed [COORD_W-1:0] ab_y;
      logic signed [COORD_W-1:0] d1_x;
      logic signed [COORD_W-1:0] d1_y;
      logic signed [PROD_W-1:0]  k_a;
      logic signed [PROD_W-1:0]  k_b;
      logic signed [PROD_W-1:0]  k_c;
      logic signed [PROD_W-1:0]  k_d;
   } s4_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ab_x;
      logic signed [COORD_W-1:0] ab_y;
      logic signed [COORD_W-1:0] d1_x;
      logic signed [COORD_W-1:0] d1_y;
      logic [PROD_W-1:0]         den;
      logic [PROD_W-1:0]         num;
   } s5_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ab_x;
      logic signed [COORD_W-1:0] ab_y;
      logic signed [COORD_W-1:0] d1_x;
      logic signed [COORD_W-1:0] d1_y;
      logic signed [COORD_W-1:0] t;
      logic                      zero;
   } s7_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ab_x;
      logic signed [COORD_W-1:0] ab_y;
      logic signed [PROD_W-1:0]  m_x;
      logic signed [PROD_W-1:0]  m_y;
      logic                      zero;
   } s8_type;

   logic                      adv;
   logic [NUM_STAGES-1:0]     vld_ff, vld_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   item_type                  s0_ff;
   s1_type                    s1_ff, s1_in;
   s2_type                    s2_ff, s2_in;
   s3_type                    s3_ff, s3_in;
   s4_type                    s4_ff, s4_in;
   s5_type                    s5_ff, s5_in;
   div_type                   div0_ff, div0_in;
   side_type                  side_ff [DIV_STEPS+1];
   side_type                  side_in;
   div_type                   chain [DIV_STEPS+1];
   s7_type                    s7_ff, s7_in;
   s8_type                    s8_ff, s8_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [COORD_W-1:0] rsp_y_ff, rsp_y_in;
   logic                      rsp_par_ff, rsp_par_in;
   logic [PROD_W-1:0]         nmag, dmag;
   logic [COORD_W-1:0]        qext;

   // base + floor(prod / 2^FRAC_BITS), saturated.
   function automatic logic signed [COORD_W-1:0] add_shift(
      input logic signed [COORD_W-1:0] base,
      input logic signed [PROD_W-1:0]  prod);
      logic signed [PROD_W-1:0] sh;
      logic signed [SUM_W-1:0]  s;
      sh = prod >>> FRAC_BITS;
      s  = SUM_W'(base) + SUM_W'(sh);
      return sat32(s);
   endfunction

   assign adv      = !rsp_valid_ff || !rsp_stall;
   assign fifo_pop = adv && !fifo_empty;
   assign vld_in   = {vld_ff[NUM_STAGES-2:0], fifo_pop};
   assign rsp_valid_in = adv ? vld_ff[NUM_STAGES-1] : rsp_valid_ff;

   always_comb begin
      s1_in.p_ab_x = mul32(geom.ba_x, s0_ff.u);
      s1_in.p_ab_y = mul32(geom.ba_y, s0_ff.u);
      s1_in.p_dc_x = mul32(geom.cd_x, s0_ff.u);
      s1_in.p_dc_y = mul32(geom.cd_y, s0_ff.u);
      s1_in.p_ad_x = mul32(geom.da_x, s0_ff.v);
      s1_in.p_ad_y = mul32(geom.da_y, s0_ff.v);
      s1_in.p_bc_x = mul32(geom.cb_x, s0_ff.v);
      s1_in.p_bc_y = mul32(geom.cb_y, s0_ff.v);

      s2_in.ab_x = add_shift(geom.a_x, s1_ff.p_ab_x);
      s2_in.ab_y = add_shift(geom.a_y, s1_ff.p_ab_y);
      s2_in.dc_x = add_shift(geom.d_x, s1_ff.p_dc_x);
      s2_in.dc_y = add_shift(geom.d_y, s1_ff.p_dc_y);
      s2_in.ad_x = add_shift(geom.a_x, s1_ff.p_ad_x);
      s2_in.ad_y = add_shift(geom.a_y, s1_ff.p_ad_y);
      s2_in.bc_x = add_shift(geom.b_x, s1_ff.p_bc_x);
      s2_in.bc_y = add_shift(geom.b_y, s1_ff.p_bc_y);

      s3_in.ab_x = s2_ff.ab_x;
      s3_in.ab_y = s2_ff.ab_y;
      s3_in.d1_x = sub_sat(s2_ff.dc_x, s2_ff.ab_x);
      s3_in.d1_y = sub_sat(s2_ff.dc_y, s2_ff.ab_y);
      s3_in.d2_x = sub_sat(s2_ff.bc_x, s2_ff.ad_x);
      s3_in.d2_y = sub_sat(s2_ff.bc_y, s2_ff.ad_y);
      s3_in.w_x  = sub_sat(s2_ff.ad_x, s2_ff.ab_x);
      s3_in.w_y  = sub_sat(s2_ff.ad_y, s2_ff.ab_y);

      s4_in.ab_x = s3_ff.ab_x;
      s4_in.ab_y = s3_ff.ab_y;
      s4_in.d1_x = s3_ff.d1_x;
      s4_in.d1_y = s3_ff.d1_y;
      s4_in.k_a  = mul32(s3_ff.d1_x, s3_ff.d2_y);
      s4_in.k_b  = mul32(s3_ff.d1_y, s3_ff.d2_x);
      s4_in.k_c  = mul32(s3_ff.w_x, s3_ff.d2_y);
      s4_in.k_d  = mul32(s3_ff.w_y, s3_ff.d2_x);

      // Both cross products are exact in 64 bits.
      s5_in.ab_x = s4_ff.ab_x;
      s5_in.ab_y = s4_ff.ab_y;
      s5_in.d1_x = s4_ff.d1_x;
      s5_in.d1_y = s4_ff.d1_y;
      s5_in.den  = s4_ff.k_a - s4_ff.k_b;
      s5_in.num  = s4_ff.k_c - s4_ff.k_d;

      nmag = s5_ff.num[PROD_W-1] ? (PROD_W'(0) - s5_ff.num) : s5_ff.num;
      dmag = s5_ff.den[PROD_W-1] ? (PROD_W'(0) - s5_ff.den) : s5_ff.den;
      side_in.ab_x = s5_ff.ab_x;
      side_in.ab_y = s5_ff.ab_y;
      side_in.d1_x = s5_ff.d1_x;
      side_in.d1_y = s5_ff.d1_y;
      side_in.neg  = s5_ff.num[PROD_W-1] ^ s5_ff.den[PROD_W-1];
      side_in.zero = (s5_ff.den == '0);
      // The quotient reaches 2^31 exactly when num >= den * 2^(31-FRAC_BITS).
      side_in.ovf  = (REM_W'(nmag) >= (REM_W'(dmag) << OVF_SHIFT));
      div0_in.rem  = REM_W'(nmag) << FRAC_BITS;
      div0_in.den  = dmag;
      div0_in.quo  = '0;

      qext       = {1'b0, chain[DIV_STEPS].quo};
      s7_in.ab_x = side_ff[DIV_STEPS].ab_x;
      s7_in.ab_y = side_ff[DIV_STEPS].ab_y;
      s7_in.d1_x = side_ff[DIV_STEPS].d1_x;
      s7_in.d1_y = side_ff[DIV_STEPS].d1_y;
      s7_in.zero = side_ff[DIV_STEPS].zero;
      if (side_ff[DIV_STEPS].ovf) begin
         s7_in.t = side_ff[DIV_STEPS].neg ? T_MIN : T_MAX;
      end else if (side_ff[DIV_STEPS].neg) begin
         s7_in.t = $signed(COORD_W'(0) - qext);
      end else begin
         s7_in.t = $signed(qext);
      end

      s8_in.ab_x = s7_ff.ab_x;
      s8_in.ab_y = s7_ff.ab_y;
      s8_in.m_x  = mul32(s7_ff.d1_x, s7_ff.t);
      s8_in.m_y  = mul32(s7_ff.d1_y, s7_ff.t);
      s8_in.zero = s7_ff.zero;

      if (s8_ff.zero) begin
         rsp_x_in = s8_ff.ab_x;
         rsp_y_in = s8_ff.ab_y;
      end else begin
         rsp_x_in = add_shift(s8_ff.ab_x, s8_ff.m_x);
         rsp_y_in = add_shift(s8_ff.ab_y, s8_ff.m_y);
      end
      rsp_par_in = s8_ff.zero;
   end

   assign chain[0] = div0_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      qpm_div_step #(
         .SHIFT(DIV_STEPS - 1 - i)
      ) u_step (
         .clock   (clock),
         .step_en (adv),
         .div_i   (chain[i]),
         .div_o   (chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff      <= fifo_item;
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         s3_ff      <= s3_in;
         s4_ff      <= s4_in;
         s5_ff      <= s5_in;
         div0_ff    <= div0_in;
         side_ff[0] <= side_in;
         for (int i = 1; i <= DIV_STEPS; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         s7_ff      <= s7_in;
         s8_ff      <= s8_in;
         rsp_x_ff   <= rsp_x_in;
         rsp_y_ff   <= rsp_y_in;
         rsp_par_ff <= rsp_par_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= vld_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mapped_x       = rsp_x_ff;
   assign rsp_mapped_y       = rsp_y_ff;
   assign rsp_lines_parallel = rsp_par_ff;

endmodule

`default_nettype wire

FILE: rtl/quad_point_map_by_line_intersection_core.sv
// Top level of the quad point mapper: front end, item queue and compute back end.
//
// Usage: the block carries a point (u,v) of the unit square, signed Q16.16 by
// default, into the quadrilateral whose corners A, B, C and D sit in eight
// configuration registers, by intersecting the line AB-DC with the line AD-BC.
// Corners are written over the csr_ channel (index 0 to 7, A.x up to D.y); the
// channel is always ready and writes to indexes above 7 are dropped. Write them
// only while no item is in flight.
// Items enter on the req_ channel and results leave on the rsp_ channel; an item
// moves when valid is high and stall is low. A result carries the mapped point,
// saturated to 32 bits, and a flag that is set when the two lines are parallel,
// in which case the point AB is returned.
// An accepted item passes the queue, an input register, the interpolation,
// cross-product and divider setup stages, 31 stages of a restoring divider
// that settles one quotient bit per stage, the scaling stages and the output
// register.
// Throughput is one item per cycle unless the receiver stalls. When it stalls
// a shown result, the whole back pipeline holds and the queue, four entries by
// default, keeps taking items until it fills; only then does req_stall rise.
// Reset clears the queue, all stage valid bits and the output valid bit, and
// loads the corners of the unit square.
`default_nettype none

module quad_point_map_by_line_intersection_core #(
   parameter int FRAC_BITS  = qpm_pkg::FRAC_BITS_DEF,
   parameter int FIFO_DEPTH = qpm_pkg::FIFO_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [qpm_pkg::COORD_W-1:0] req_point_u,
   input  logic signed [qpm_pkg::COORD_W-1:0] req_point_v,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [qpm_pkg::COORD_W-1:0] rsp_mapped_x,
   output logic signed [qpm_pkg::COORD_W-1:0] rsp_mapped_y,
   output logic                               rsp_lines_parallel,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [qpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qpm_pkg::COORD_W-1:0]        csr_wdata
);
   import qpm_pkg::*;

   geom_type geom;
   item_type push_item;
   item_type pop_item;
   logic     fifo_push;
   logic     fifo_pop;
   logic     fifo_full;
   logic     fifo_empty;

   // The front takes items and register writes and keeps corner differences.
   qpm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_point_u (req_point_u),
      .req_point_v (req_point_v),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fifo_full   (fifo_full),
      .fifo_push   (fifo_push),
      .fifo_item   (push_item),
      .geom        (geom)
   );

   // The queue lets the front keep accepting while the back end is held.
   qpm_fifo #(
      .DEPTH(FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_item (push_item),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_item  (pop_item),
      .empty     (fifo_empty)
   );

   // The back end does the per-item arithmetic and owns the output register.
   qpm_back #(
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .geom               (geom),
      .fifo_empty         (fifo_empty),
      .fifo_item          (pop_item),
      .fifo_pop           (fifo_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mapped_x       (rsp_mapped_x),
      .rsp_mapped_y       (rsp_mapped_y),
      .rsp_lines_parallel (rsp_lines_parallel)
   );

endmodule

`default_nettype wire

FILE: rtl/qpm_checker.sv
// Port-level checks for the quad point mapper, bound to the top level.
`default_nettype none

module qpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [31:0] req_point_u,
   input logic [31:0] req_point_v,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_mapped_x,
   input logic [31:0] rsp_mapped_y,
   input logic        rsp_lines_parallel
);

   logic [7:0] pending_ff, pending_in;
   logic       in_take, out_take;

   assign in_take  = req_valid && !req_stall;
   assign out_take = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (in_take && !out_take) begin
         pending_in = pending_ff + 8'd1;
      end else if (out_take && !in_take) begin
         pending_in = pending_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_req_holds: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_point_u) && $stable(req_point_v))
      else $error("request changed while stalled");

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_rsp_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_mapped_x) && $stable(rsp_mapped_y)
                                 && $stable(rsp_lines_parallel))
      else $error("result changed while stalled");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("result shown with no item in flight");

endmodule

bind quad_point_map_by_line_intersection_core qpm_checker u_qpm_checker (.*);

`default_nettype wire

FILE: bench/qpm_checker.sv
// Watches the quad point mapper's channels, predicts every mapped point and compares results.
module qpm_scoreboard (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic signed [qpm_pkg::COORD_W-1:0] req_point_u,
   input  logic signed [qpm_pkg::COORD_W-1:0] req_point_v,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [qpm_pkg::COORD_W-1:0] rsp_mapped_x,
   input  logic signed [qpm_pkg::COORD_W-1:0] rsp_mapped_y,
   input  logic                               rsp_lines_parallel,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [qpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qpm_pkg::COORD_W-1:0]        csr_wdata,
   output int                                 mismatch_count,
   output int                                 points_outstanding,
   output int                                 parallel_seen
);
   import qpm_pkg::*;

   localparam int FB = FRAC_BITS_DEF;

   typedef logic signed [SUM_W-1:0] wide_type;
   typedef logic signed [COORD_W-1:0] word_type;

   typedef struct {
      word_type x;
      word_type y;
      logic     parallel;
   } mapped_point_type;

   word_type         corners [NUM_CSR];
   mapped_point_type expected_points [$];

   function automatic word_type clamp_word(input wide_type x);
      if (x > SAT_MAX) return T_MAX;
      if (x < SAT_MIN) return T_MIN;
      return x[COORD_W-1:0];
   endfunction

   // Arithmetic shift of a signed value is a floor division by a power of two.
   function automatic word_type blend(input word_type base, input word_type other,
                                      input word_type c);
      wide_type diff;
      wide_type prod;
      diff = clamp_word(wide_type'(other) - wide_type'(base));
      prod = diff * wide_type'(c);
      return clamp_word(wide_type'(base) + (prod >>> FB));
   endfunction

   // num * 2^FB / den toward zero, restoring one fraction bit per step.
   function automatic word_type line_param(input wide_type num, input wide_type den);
      logic             neg;
      logic [SUM_W-1:0] n;
      logic [SUM_W-1:0] d;
      logic [SUM_W-1:0] q;
      logic [SUM_W-1:0] r;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = n / d;
      r = n % d;
      if (q > (SUM_W'(1) << (32 - FB))) q = SUM_W'(1) << (32 - FB);
      for (int i = 0; i < FB; i++) begin
         q = q << 1;
         if (r >= d - r) begin
            r = r - (d - r);
            q[0] = 1'b1;
         end else begin
            r = r << 1;
         end
      end
      if (neg) begin
         if (q >= 66'h8000_0000) return T_MIN;
         return -q[COORD_W-1:0];
      end
      if (q > 66'h7FFF_FFFF) return T_MAX;
      return q[COORD_W-1:0];
   endfunction

   function automatic mapped_point_type map_point(input word_type u, input word_type v);
      mapped_point_type res;
      word_type ab_x, ab_y, dc_x, dc_y, ad_x, ad_y, bc_x, bc_y;
      word_type d1_x, d1_y, d2_x, d2_y, w_x, w_y, t;
      wide_type den, num;
      ab_x = blend(corners[CSR_A_X], corners[CSR_B_X], u);
      ab_y = blend(corners[CSR_A_Y], corners[CSR_B_Y], u);
      dc_x = blend(corners[CSR_D_X], corners[CSR_C_X], u);
      dc_y = blend(corners[CSR_D_Y], corners[CSR_C_Y], u);
      ad_x = blend(corners[CSR_A_X], corners[CSR_D_X], v);
      ad_y = blend(corners[CSR_A_Y], corners[CSR_D_Y], v);
      bc_x = blend(corners[CSR_B_X], corners[CSR_C_X], v);
      bc_y = blend(corners[CSR_B_Y], corners[CSR_C_Y], v);
      d1_x = clamp_word(wide_type'(dc_x) - wide_type'(ab_x));
      d1_y = clamp_word(wide_type'(dc_y) - wide_type'(ab_y));
      d2_x = clamp_word(wide_type'(bc_x) - wide_type'(ad_x));
      d2_y = clamp_word(wide_type'(bc_y) - wide_type'(ad_y));
      w_x  = clamp_word(wide_type'(ad_x) - wide_type'(ab_x));
      w_y  = clamp_word(wide_type'(ad_y) - wide_type'(ab_y));
      den = wide_type'(d1_x) * wide_type'(d2_y) - wide_type'(d1_y) * wide_type'(d2_x);
      num = wide_type'(w_x) * wide_type'(d2_y) - wide_type'(w_y) * wide_type'(d2_x);
      res.x = ab_x;
      res.y = ab_y;
      res.parallel = 1'b1;
      if (den != 0) begin
         t = line_param(num, den);
         res.x = clamp_word(wide_type'(ab_x) + ((wide_type'(d1_x) * wide_type'(t)) >>> FB));
         res.y = clamp_word(wide_type'(ab_y) + ((wide_type'(d1_y) * wide_type'(t)) >>> FB));
         res.parallel = 1'b0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      mapped_point_type want;
      logic             bad;
      if (reset) begin
         for (int i = 0; i < NUM_CSR; i++) corners[i] = CSR_RESET[i];
         expected_points.delete();
         mismatch_count = 0;
         parallel_seen = 0;
      end else begin
         if (csr_valid && csr_ready && csr_index < NUM_CSR)
            corners[csr_index[CSR_SEL_W-1:0]] = csr_wdata;
         if (req_valid && !req_stall) expected_points.push_back(map_point(req_point_u, req_point_v));
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result with nothing expected: x=%0d y=%0d par=%0b",
                           rsp_mapped_x, rsp_mapped_y, rsp_lines_parallel);
            end else begin
               want = expected_points.pop_front();
               bad = (want.x !== rsp_mapped_x) || (want.y !== rsp_mapped_y) ||
                     (want.parallel !== rsp_lines_parallel);
               if (rsp_lines_parallel === 1'b1) parallel_seen++;
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: x exp %0d got %0d, y exp %0d got %0d, par exp %0b got %0b",
                              want.x, rsp_mapped_x, want.y, rsp_mapped_y,
                              want.parallel, rsp_lines_parallel);
               end
            end
         end
      end
      points_outstanding = expected_points.size();
   end

endmodule

FILE: bench/tb_top.sv
// Stimulus and verdict for the quad point mapper, with the checker beside the block.
module tb_top;
   import qpm_pkg::*;

   // An index past the last corner register; writes to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] UNUSED_INDEX = 4'd11;
   localparam int ONE = 32'h0001_0000;
   localparam int DRAIN_CYCLES = 60;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_point_u;
   logic signed [COORD_W-1:0] req_point_v;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [COORD_W-1:0] rsp_mapped_x;
   logic signed [COORD_W-1:0] rsp_mapped_y;
   logic                      rsp_lines_parallel;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [COORD_W-1:0]        csr_wdata;

   int mismatch_count;
   int points_outstanding;
   int parallel_seen;
   int points_sent;

   // When set, neither side idles; this is used for the closing stretch.
   logic steady;
   // When set, the receiver holds off for one long stretch.
   logic long_hold;

   quad_point_map_by_line_intersection_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_u(req_point_u), .req_point_v(req_point_v),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_mapped_x(rsp_mapped_x), .rsp_mapped_y(rsp_mapped_y),
      .rsp_lines_parallel(rsp_lines_parallel),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   qpm_scoreboard u_scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_u(req_point_u), .req_point_v(req_point_v),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_mapped_x(rsp_mapped_x), .rsp_mapped_y(rsp_mapped_y),
      .rsp_lines_parallel(rsp_lines_parallel),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .points_outstanding(points_outstanding),
      .parallel_seen(parallel_seen)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Writes all eight corners, then one write to an unused index with random
   // data, in a single burst. The handshake is judged on values that are stable
   // at the falling edge, and the write lands on the following rising edge.
   task automatic load_quad(input logic [COORD_W-1:0] corner_vals [NUM_CSR]);
      logic ready_seen;
      for (int i = 0; i <= NUM_CSR; i++) begin
         csr_valid <= 1'b1;
         csr_index <= (i == NUM_CSR) ? UNUSED_INDEX : CSR_IDX_W'(i);
         csr_wdata <= (i == NUM_CSR) ? $urandom : corner_vals[i];
         do begin
            @(negedge clock);
            ready_seen = csr_ready;
            @(posedge clock);
         end while (!ready_seen);
      end
      csr_valid <= 1'b0;
   endtask

   // Offers one point and returns at the rising edge that accepts it. The valid
   // stays high into the next call unless that call opens a gap.
   task automatic send_point(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
      logic stall_seen;
      if (!steady && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_point_u <= u;
      req_point_v <= v;
      do begin
         @(negedge clock);
         stall_seen = req_stall;
         @(posedge clock);
      end while (stall_seen);
      points_sent++;
   endtask

   // Lets the block drain so that the corner registers may change safely.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (points_outstanding != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   // Mostly points near the unit square, a share of them with full-range bits.
   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2:       return ONE * $urandom_range(0, 1);
         default: return $urandom_range(0, 3 * ONE) - ONE;
      endcase
   endfunction

   // The receiver stalls in short random bursts, once for a long stretch, and
   // never while the run is in its steady closing stretch.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (150) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (!steady && !reset && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #20_000_000;
      $display("timeout with %0d points still outstanding", points_outstanding);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [COORD_W-1:0] quad [NUM_CSR];
      logic [COORD_W-1:0] edge_vals [8];
      int                 rounds;

      req_valid   = 1'b0;
      req_point_u = '0;
      req_point_v = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      steady      = 1'b0;
      long_hold   = 1'b0;
      points_sent = 0;
      reset       = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points against the reset corners: edge values such as zero, one,
      // one half and the extremes paired with one another, then the corner (1,1)
      // and the extremes of both fields, which drive the interpolation into saturation.
      edge_vals = '{32'h0, ONE, 32'h8000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'hFFFF_FFFF, 32'h1, 32'hFFFF_0000};
      foreach (edge_vals[i]) send_point(edge_vals[i], edge_vals[(i + 3) % 8]);
      send_point(ONE, ONE);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000);
      wait_idle();

      // A collapsed quad: every corner the same point, so the lines are
      // parallel and the point AB comes back flagged.
      foreach (quad[i]) quad[i] = 32'h0003_0000;
      load_quad(quad);
      send_point(32'h4000, 32'hC000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      // A quad with the far corners at opposite extremes, so that differences
      // and the intersection both overflow.
      wait_idle();
      quad = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      load_quad(quad);
      foreach (edge_vals[i]) send_point(edge_vals[i], edge_vals[7 - i]);
      wait_idle();

      // Random phases. Each picks a new quad: a small convex-ish one, a fully
      // random one, an extreme one or a degenerate one whose edges are
      // parallel. The receiver's long hold falls into the second phase while
      // the sender keeps offering points, so the queue fills and the input
      // stalls.
      for (rounds = 0; rounds < 6; rounds++) begin
         case (rounds % 4)
            0: foreach (quad[i]) quad[i] = $urandom_range(0, 4 * ONE) - 2 * ONE;
            1: foreach (quad[i]) quad[i] = $urandom;
            2: foreach (quad[i]) quad[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: begin
               // A quad squashed to a line: A, B, C, D all on one line.
               quad = '{32'h0, 32'h0, ONE, ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE};
            end
         endcase
         load_quad(quad);
         if (rounds == 1) long_hold = 1'b1;
         if (rounds == 5) steady = 1'b1;
         repeat (100) send_point(pick_coord(), pick_coord());
         wait_idle();
      end

      // Back to the unit square through the write port, so the reset values
      // are also reached by a write.
      foreach (quad[i]) quad[i] = CSR_RESET[i];
      load_quad(quad);
      repeat (20) send_point(pick_coord(), pick_coord());
      req_valid <= 1'b0;
      @(posedge clock);
      while (points_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d points over 10 corner settings, %0d flagged as parallel",
               points_sent, parallel_seen);
      $display("including saturated corners, full-range coordinates and a long output hold");
      if (mismatch_count == 0 && points_outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, points_outstanding);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/qpm_pkg.sv
rtl/qpm_fifo.sv
rtl/qpm_front.sv
rtl/qpm_div_step.sv
rtl/qpm_back.sv
rtl/quad_point_map_by_line_intersection_core.sv
rtl/qpm_checker.sv
bench/qpm_checker.sv
bench/tb_top.sv
